// ----- hdl/sorted_list_to_fifo_buffer_defines.svh -----
// assertion macros shared by the sorted list block
`ifndef SORTED_LIST_TO_FIFO_BUFFER_DEFINES_SVH
`define SORTED_LIST_TO_FIFO_BUFFER_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SLFB_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define SLFB_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/slfb_pkg.sv -----
`default_nettype none

package slfb_pkg;

  localparam int DEPTH_DEF = 16;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_CLEAR    = 3'd1,
    OP_XFER     = 3'd2,
    OP_RD_LIST  = 3'd3,
    OP_RD_QUEUE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_EMIT,
    S_RD_WAIT,
    S_RD_DATA
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/slfb_if.sv -----
`default_nettype none

// command channel
interface slfb_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

// result channel
interface slfb_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, output data, output status, output last, input ready);
  modport sink (input valid, input data, input status, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/sorted_list_to_fifo_buffer.sv -----
`default_nettype none
// insert: scans from the top entry down, at most list size entries, S_INS_RD then S_INS_CMP each,
//   one compare/move per entry via the list bank's registered read and write port, status via S_EMIT
// clear, transfer and an insert into an empty or full list give their beat from the S_EMIT state
// reads: per beat a registered memory read, then the output register; ready only when idle
// reset: synchronous, active high; clears counts, bank select, state and output valid
// memory contents are not cleared, entries above the counts are never read
`include "sorted_list_to_fifo_buffer_defines.svh"

module sorted_list_to_fifo_buffer #(
  parameter int DEPTH = slfb_pkg::DEPTH_DEF
) (
  input wire logic          clk,
  input wire logic          rst,
  slfb_cmd_if.sink          cmd,
  slfb_res_if.source        res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // two banks; sel picks which one is the list, the other is the queue.
  // a transfer just swaps roles, so the old queue bank becomes the empty list
  logic signed [31:0] mem_a [DEPTH];
  logic signed [31:0] mem_b [DEPTH];
  logic signed [31:0] rd_a;
  logic signed [31:0] rd_b;
  logic               sel;
  logic               sel_next;

  slfb_pkg::state_t   state;
  slfb_pkg::state_t   state_next;

  logic [CW-1:0]      list_count;
  logic [CW-1:0]      list_count_next;
  logic [CW-1:0]      queue_count;
  logic [CW-1:0]      queue_count_next;

  // shared scan index: drives the read address of both banks
  logic [AW-1:0]      idx;
  logic [AW-1:0]      idx_next;
  logic signed [31:0] val;
  logic signed [31:0] val_next;
  logic [CW-1:0]      rd_cnt;
  logic [CW-1:0]      rd_cnt_next;
  logic               rd_queue;
  logic               rd_queue_next;
  slfb_pkg::status_t  pend;
  slfb_pkg::status_t  pend_next;

  // list memory write port
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;

  // output register
  logic               out_valid;
  logic signed [31:0] out_data;
  slfb_pkg::status_t  out_status;
  logic               out_last;
  logic               out_load;
  logic signed [31:0] out_data_next;
  slfb_pkg::status_t  out_status_next;
  logic               out_last_next;

  logic               out_free;
  logic               acc;
  logic signed [31:0] list_rdata;
  logic signed [31:0] src_rdata;
  logic               shift_up;
  logic               rd_is_last;

  assign cmd.ready  = (state == slfb_pkg::S_IDLE);
  assign acc        = cmd.valid && cmd.ready;
  assign out_free   = !out_valid || res.ready;

  assign list_rdata = sel ? rd_b : rd_a;
  assign src_rdata  = (rd_queue ^ sel) ? rd_b : rd_a;
  // stored entry not smaller than the new value moves up one slot
  assign shift_up   = (list_rdata >= val);
  assign rd_is_last = ((CW'(idx) + CW'(1)) == rd_cnt);

  assign res.valid  = out_valid;
  assign res.data   = out_data;
  assign res.status = out_status;
  assign res.last   = out_last;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      slfb_pkg::S_IDLE: begin
        if (acc) begin
          case (cmd.op)
            slfb_pkg::OP_INSERT: begin
              if (list_count == CW'(DEPTH) || list_count == '0) begin
                state_next = slfb_pkg::S_EMIT;
              end else begin
                state_next = slfb_pkg::S_INS_RD;
              end
            end
            slfb_pkg::OP_CLEAR,
            slfb_pkg::OP_XFER: state_next = slfb_pkg::S_EMIT;
            slfb_pkg::OP_RD_LIST: begin
              state_next = (list_count == '0) ? slfb_pkg::S_EMIT : slfb_pkg::S_RD_WAIT;
            end
            slfb_pkg::OP_RD_QUEUE: begin
              state_next = (queue_count == '0) ? slfb_pkg::S_EMIT : slfb_pkg::S_RD_WAIT;
            end
            default: state_next = slfb_pkg::S_IDLE;
          endcase
        end
      end
      slfb_pkg::S_INS_RD: state_next = slfb_pkg::S_INS_CMP;
      slfb_pkg::S_INS_CMP: begin
        if (!shift_up) begin
          state_next = slfb_pkg::S_EMIT;
        end else if (idx == '0) begin
          state_next = slfb_pkg::S_INS_PUT;
        end else begin
          state_next = slfb_pkg::S_INS_RD;
        end
      end
      slfb_pkg::S_INS_PUT: state_next = slfb_pkg::S_EMIT;
      slfb_pkg::S_EMIT: begin
        if (out_free) state_next = slfb_pkg::S_IDLE;
      end
      slfb_pkg::S_RD_WAIT: state_next = slfb_pkg::S_RD_DATA;
      slfb_pkg::S_RD_DATA: begin
        if (out_free) state_next = rd_is_last ? slfb_pkg::S_IDLE : slfb_pkg::S_RD_WAIT;
      end
      default: state_next = slfb_pkg::S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    sel_next         = sel;
    list_count_next  = list_count;
    queue_count_next = queue_count;
    idx_next         = idx;
    val_next         = val;
    rd_cnt_next      = rd_cnt;
    rd_queue_next    = rd_queue;
    pend_next        = pend;
    mem_we           = 1'b0;
    mem_waddr        = idx;
    mem_wdata        = val;
    out_load         = 1'b0;
    out_data_next    = '0;
    out_status_next  = slfb_pkg::ST_OK;
    out_last_next    = 1'b1;
    case (state)
      slfb_pkg::S_IDLE: begin
        if (acc) begin
          case (cmd.op)
            slfb_pkg::OP_INSERT: begin
              val_next = cmd.value;
              if (list_count == CW'(DEPTH)) begin
                pend_next = slfb_pkg::ST_FULL;
              end else if (list_count == '0) begin
                // empty list: store directly at the bottom
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata       = cmd.value;
                list_count_next = CW'(1);
                pend_next       = slfb_pkg::ST_OK;
              end else begin
                // scan from the top entry downward
                idx_next = AW'(list_count - CW'(1));
              end
            end
            slfb_pkg::OP_CLEAR: begin
              pend_next       = (list_count == '0) ? slfb_pkg::ST_EMPTY : slfb_pkg::ST_OK;
              list_count_next = '0;
            end
            slfb_pkg::OP_XFER: begin
              if (list_count == '0) begin
                pend_next = slfb_pkg::ST_EMPTY;
              end else begin
                sel_next         = !sel;
                queue_count_next = list_count;
                list_count_next  = '0;
                pend_next        = slfb_pkg::ST_OK;
              end
            end
            slfb_pkg::OP_RD_LIST: begin
              rd_queue_next = 1'b0;
              rd_cnt_next   = list_count;
              idx_next      = '0;
              pend_next     = slfb_pkg::ST_EMPTY;
            end
            slfb_pkg::OP_RD_QUEUE: begin
              rd_queue_next = 1'b1;
              rd_cnt_next   = queue_count;
              idx_next      = '0;
              pend_next     = slfb_pkg::ST_EMPTY;
            end
            default: ;
          endcase
        end
      end
      slfb_pkg::S_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = idx + AW'(1);
        if (shift_up) begin
          mem_wdata = list_rdata;
          if (idx != '0) idx_next = idx - AW'(1);
        end else begin
          mem_wdata       = val;
          list_count_next = list_count + CW'(1);
          pend_next       = slfb_pkg::ST_OK;
        end
      end
      slfb_pkg::S_INS_PUT: begin
        mem_we          = 1'b1;
        mem_waddr       = '0;
        mem_wdata       = val;
        list_count_next = list_count + CW'(1);
        pend_next       = slfb_pkg::ST_OK;
      end
      slfb_pkg::S_EMIT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_next = pend;
        end
      end
      slfb_pkg::S_RD_DATA: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_data_next = src_rdata;
          out_last_next = rd_is_last;
          if (!rd_is_last) idx_next = idx + AW'(1);
        end
      end
      default: ;
    endcase
  end

  // banks: one write port on the list bank, registered read at the scan index
  always_ff @(posedge clk) begin
    if (mem_we && !sel) mem_a[mem_waddr] <= mem_wdata;
    if (mem_we && sel) mem_b[mem_waddr] <= mem_wdata;
    rd_a <= mem_a[idx];
    rd_b <= mem_b[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= slfb_pkg::S_IDLE;
      sel         <= 1'b0;
      list_count  <= '0;
      queue_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      sel         <= sel_next;
      list_count  <= list_count_next;
      queue_count <= queue_count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    val      <= val_next;
    rd_cnt   <= rd_cnt_next;
    rd_queue <= rd_queue_next;
    pend     <= pend_next;
    if (out_load) begin
      out_data   <= out_data_next;
      out_status <= out_status_next;
      out_last   <= out_last_next;
    end
  end

  `SLFB_AST_IMP(a_cnt_bound, 1'b1, (list_count <= CW'(DEPTH)) && (queue_count <= CW'(DEPTH)), "count beyond depth")
  `SLFB_AST_IMP(a_ins_room, state == slfb_pkg::S_INS_CMP, (list_count < CW'(DEPTH)) && (CW'(idx) < list_count), "insert scan out of range")
  `SLFB_AST_IMP(a_rd_idx, state == slfb_pkg::S_RD_DATA, CW'(idx) < rd_cnt, "read index past count")
  `SLFB_AST_NXT(a_xfer, acc && (cmd.op == slfb_pkg::OP_XFER) && (list_count != '0), (list_count == '0) && (queue_count == $past(list_count)), "transfer did not move list")

endmodule

`default_nettype wire
